### design/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

### design/uart_rm_pkg.sv
package uart_rm_pkg;

  // Request opcodes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_HOST  = 2'd2;

  // Register offsets
  localparam logic [2:0] OFF_DATA = 3'd0;
  localparam logic [2:0] OFF_IER  = 3'd1;
  localparam logic [2:0] OFF_IIR  = 3'd2;
  localparam logic [2:0] OFF_LCR  = 3'd3;
  localparam logic [2:0] OFF_LSR  = 3'd5;
  localparam logic [2:0] OFF_SCR  = 3'd7;

  // Interrupt identification codes
  localparam logic [7:0] IIR_NONE = 8'h01;
  localparam logic [7:0] IIR_TX   = 8'h02;
  localparam logic [7:0] IIR_RX   = 8'h04;

  localparam logic [7:0] LSR_RESET = 8'h60;

  // Bit positions
  localparam int DLAB_BIT  = 7;
  localparam int DR_BIT    = 0;
  localparam int IER_RX_EN = 0;
  localparam int IER_TX_EN = 1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] offset;
    logic [7:0] wr_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq_level;
    logic       rx_dropped;
  } result_t;

endpackage

### design/uart_rm_regs.sv
module uart_rm_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_accept,
  input  uart_rm_pkg::req_t    req,
  output uart_rm_pkg::result_t res
);
  import uart_rm_pkg::*;

  logic [7:0] rf_r   [8];
  logic [7:0] rf_nxt [8];
  logic [7:0] dl_r   [2];
  logic [7:0] dl_nxt [2];
  logic       irq_r;
  logic       irq_nxt;

  logic dlab;
  logic tx_en;
  logic rx_en;
  logic rx_pend;
  logic dl_sel;

  assign dlab    = rf_r[OFF_LCR][DLAB_BIT];
  assign tx_en   = rf_r[OFF_IER][IER_TX_EN];
  assign rx_en   = rf_r[OFF_IER][IER_RX_EN];
  assign rx_pend = (rf_r[OFF_IIR] == IIR_RX);
  assign dl_sel  = dlab && (req.offset[2:1] == 2'b00);

  always_comb begin
    rf_nxt         = rf_r;
    dl_nxt         = dl_r;
    irq_nxt        = irq_r;
    res.read_data  = 8'h00;
    res.tx_valid   = 1'b0;
    res.tx_byte    = 8'h00;
    res.rx_dropped = 1'b0;
    case (req.opcode)
      OP_READ: begin
        if (dl_sel) begin
          res.read_data = dl_r[req.offset[0]];
        end else if (req.offset == OFF_SCR) begin
          res.read_data = 8'h00;
        end else if (req.offset == OFF_IIR) begin
          res.read_data = rf_r[OFF_IIR];
          // keep a transmit interrupt behind a serviced receive one
          if (rx_pend && tx_en) begin
            rf_nxt[OFF_IIR] = IIR_TX;
          end else begin
            rf_nxt[OFF_IIR] = IIR_NONE;
            irq_nxt         = 1'b0;
          end
        end else if (req.offset == OFF_DATA) begin
          res.read_data          = rf_r[OFF_DATA];
          rf_nxt[OFF_LSR][DR_BIT] = 1'b0;
        end else begin
          res.read_data = rf_r[req.offset];
        end
      end
      OP_WRITE: begin
        if (dl_sel) begin
          dl_nxt[req.offset[0]] = req.wr_data;
        end else if (req.offset == OFF_DATA) begin
          res.tx_valid = 1'b1;
          res.tx_byte  = req.wr_data;
          if (tx_en && !rx_pend) begin
            rf_nxt[OFF_IIR] = IIR_TX;
            irq_nxt         = 1'b1;
          end
        end else begin
          rf_nxt[req.offset] = req.wr_data;
        end
      end
      OP_HOST: begin
        if (rf_r[OFF_LSR][DR_BIT]) begin
          res.rx_dropped = 1'b1;
        end else begin
          rf_nxt[OFF_DATA]        = req.wr_data;
          rf_nxt[OFF_LSR][DR_BIT] = 1'b1;
          if (rx_en) begin
            rf_nxt[OFF_IIR] = IIR_RX;
            irq_nxt         = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res.irq_level = irq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_r    <= '{8'h00, 8'h00, IIR_NONE, 8'h00, 8'h00, LSR_RESET, 8'h00, 8'h00};
      dl_r[0] <= 8'h00;
      dl_r[1] <= 8'h00;
      irq_r   <= 1'b0;
    end else if (req_accept) begin
      rf_r  <= rf_nxt;
      dl_r  <= dl_nxt;
      irq_r <= irq_nxt;
    end
  end

endmodule

### design/uart_rm_outq.sv
module uart_rm_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  uart_rm_pkg::result_t push_data,
  input  logic                 pop_ready,
  output logic                 head_valid,
  output uart_rm_pkg::result_t head_data,
  output logic                 full
);
  import uart_rm_pkg::*;

  `include "assert_macros.svh"

  result_t    slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       pop;

  assign head_valid = (count_r != 2'd0);
  assign full       = (count_r == 2'd2);
  assign head_data  = slot_r[rd_ptr_r];
  assign pop        = head_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_CLK(a_no_overflow, !(push && full), "push into full result queue")
  `ASSERT_CLK(a_ptr_count, (count_r != 2'd1) || (wr_ptr_r != rd_ptr_r),
              "pointers disagree with count")
  `ASSERT_NEXT(a_push_shows, push, head_valid, "pushed result not visible")

endmodule

### design/uart_register_model.sv
// Register model of a 16550-style UART. Each request is a bus read, a bus
// write (offsets 0 to 7) or a byte arriving from the host side, and each
// request yields exactly one result: the read byte, a transmitted byte when
// the data register is written, the interrupt line level after the request,
// and a flag for a host byte dropped because data-ready was still set.
// The register file, divisor latch and interrupt line update in the cycle a
// request is accepted, so one request per clock is sustained while the result
// queue has room; its result is registered into that queue. A two-entry result
// queue lets the block keep taking requests while one result waits; in_ready
// drops only when both entries are held.
module uart_register_model (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic [2:0] in_offset,
  input  logic [7:0] in_wr_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_irq_level,
  output logic       out_rx_dropped
);
  import uart_rm_pkg::*;

  `include "assert_macros.svh"

  req_t    req;
  result_t step_res;
  result_t head_res;
  logic    accept;
  logic    q_full;

  // Bundle the incoming request.
  assign req.opcode  = in_opcode;
  assign req.offset  = in_offset;
  assign req.wr_data = in_wr_data;

  // Take a request whenever the result queue has room.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Register state and the per-request update.
  uart_rm_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_accept (accept),
    .req        (req),
    .res        (step_res)
  );

  // Hold results until the consumer takes them.
  uart_rm_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (step_res),
    .pop_ready  (out_ready),
    .head_valid (out_valid),
    .head_data  (head_res),
    .full       (q_full)
  );

  assign out_read_data  = head_res.read_data;
  assign out_tx_valid   = head_res.tx_valid;
  assign out_tx_byte    = head_res.tx_byte;
  assign out_irq_level  = head_res.irq_level;
  assign out_rx_dropped = head_res.rx_dropped;

  // A transmit comes only from a write, which returns no read data.
  `ASSERT_CLK(a_tx_no_rd, !(out_valid && out_tx_valid) || (out_read_data == 8'h00),
              "transmit result carries read data")
  // A dropped host byte never transmits.
  `ASSERT_CLK(a_drop_no_tx, !(out_valid && out_rx_dropped) || !out_tx_valid,
              "dropped byte result also transmits")
  // Backpressure only when a result is waiting.
  `ASSERT_CLK(a_stall_has_out, in_ready || out_valid, "stalled with no pending result")

endmodule
